// File: hdl/semaphore_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Semaphore table engine assertion macros
// Concurrent assertion wrappers shared by the engine RTL. Defining
// NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_TABLE_ENGINE_DEFINES_SVH
`define SEMAPHORE_TABLE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define STE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define STE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define STE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/ste_pkg.sv
// ----------------------------------------------------------------------------
// Semaphore table engine package
// Field widths, operation codes, saturation limits and the types shared
// between the engine modules.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int STE_NUM_SLOTS = 64;

    // The free-slot search looks at the flags in groups of this many.
    localparam int STE_GROUP     = 16;
    localparam int STE_GPOS_W    = $clog2(STE_GROUP);

    localparam int SLOT_W        = 6;
    localparam int INIT_W        = 15;
    localparam int OWNER_W       = 8;
    localparam int COUNT_W       = 16;

    localparam logic signed [COUNT_W-1:0] CNT_MAX = 16'h7fff;
    localparam logic signed [COUNT_W-1:0] CNT_MIN = 16'h8000;

    localparam logic STS_OK      = 1'b0;
    localparam logic STS_NO_SLOT = 1'b1;

    typedef enum logic [1:0] {
        FN_CREATE  = 2'd0,
        FN_DESTROY = 2'd1,
        FN_WAIT    = 2'd2,
        FN_SIGNAL  = 2'd3
    } t_func;

    typedef struct packed {
        logic [OWNER_W-1:0]        owner;
        logic signed [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic claim;
        logic free_en;
    } t_flag_ctl;

endpackage

// File: hdl/ste_req_if.sv
// ----------------------------------------------------------------------------
// Semaphore table request channel
// Valid/ready channel that carries one semaphore operation.
// ----------------------------------------------------------------------------
interface ste_req_if;
    import ste_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [SLOT_W-1:0]  slot_index;
    logic [INIT_W-1:0]  initial_count;
    logic [OWNER_W-1:0] owner_thread;

    modport source (
        output valid, func, slot_index, initial_count, owner_thread,
        input  ready
    );

    modport sink (
        input  valid, func, slot_index, initial_count, owner_thread,
        output ready
    );

endinterface

// File: hdl/ste_rsp_if.sv
// ----------------------------------------------------------------------------
// Semaphore table response channel
// Valid/ready channel that carries the outcome of one operation.
// ----------------------------------------------------------------------------
interface ste_rsp_if;
    import ste_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [SLOT_W-1:0]         granted_slot;
    logic                      must_block;
    logic                      wake_one;
    logic signed [COUNT_W-1:0] count_after;

    modport source (
        output valid, status, granted_slot, must_block, wake_one, count_after,
        input  ready
    );

    modport sink (
        input  valid, status, granted_slot, must_block, wake_one, count_after,
        output ready
    );

endinterface

// File: hdl/semaphore_table_engine.sv
// An accepted request moves to ST_EXEC; its result is registered as it
// leaves. The entry memory read-modify-write and the two-stage free-slot
// search keep it there, as does a held result; ready is low until then.
// Reset: the in-use flags and the search pointer clear at once, no clearing
// pass; owner and count entries are undefined until a create writes them.
// ----------------------------------------------------------------------------
// Semaphore table engine
// Table of counting semaphores with create, destroy, wait and signal
// operations on a shared entry memory.
// ----------------------------------------------------------------------------
`include "semaphore_table_engine_defines.svh"

module semaphore_table_engine #(
    parameter int NUM_SLOTS = ste_pkg::STE_NUM_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ste_req_if.sink   i_req,
    ste_rsp_if.source o_rsp
);
    import ste_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state                    r_state;
    t_func                     r_func;
    logic [SLOT_W-1:0]         r_slot;
    logic [INIT_W-1:0]         r_init;
    logic [OWNER_W-1:0]        r_owner;
    logic                      r_oor;
    logic                      r_out_valid;
    logic                      r_status;
    logic [SLOT_W-1:0]         r_gslot;
    logic                      r_block;
    logic                      r_wake;
    logic signed [COUNT_W-1:0] r_count;

    logic                      n_status;
    logic [SLOT_W-1:0]         n_gslot;
    logic                      n_block;
    logic                      n_wake;
    logic signed [COUNT_W-1:0] n_count;

    logic                      w_accept;
    logic                      w_finish;
    logic                      w_oor_in;
    logic                      w_found;
    logic [SW-1:0]             w_cand;
    t_entry                    w_rd_data;
    logic                      w_wr_en;
    logic [SW-1:0]             w_wr_addr;
    t_entry                    w_wr_data;
    t_flag_ctl                 w_ctl;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_finish    = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);
    assign w_oor_in    = int'(i_req.slot_index) >= NUM_SLOTS;

    ste_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept && !w_oor_in),
        .i_rd_addr (SW'(i_req.slot_index)),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    ste_search #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_free_slot (SW'(r_slot)),
        .o_found     (w_found),
        .o_cand      (w_cand)
    );

    // Operation datapath, evaluated while a request is in ST_EXEC. The
    // memory and flag updates only fire in the cycle the result is registered.
    always_comb begin
        logic signed [COUNT_W-1:0] c;
        c             = w_rd_data.count;
        n_status      = STS_OK;
        n_gslot       = r_slot;
        n_block       = 1'b0;
        n_wake        = 1'b0;
        n_count       = '0;
        w_wr_en       = 1'b0;
        w_wr_addr     = SW'(r_slot);
        w_wr_data     = w_rd_data;
        w_ctl.capture = w_accept;
        w_ctl.claim   = 1'b0;
        w_ctl.free_en = 1'b0;
        case (r_func)
            FN_CREATE: begin
                if (w_found) begin
                    n_gslot         = SLOT_W'(w_cand);
                    n_count         = signed'({1'b0, r_init});
                    w_wr_en         = w_finish;
                    w_wr_addr       = w_cand;
                    w_wr_data.owner = r_owner;
                    w_wr_data.count = signed'({1'b0, r_init});
                    w_ctl.claim     = w_finish;
                end else begin
                    n_status = STS_NO_SLOT;
                    n_gslot  = '0;
                end
            end
            FN_DESTROY: begin
                if (!r_oor) begin
                    n_count       = w_rd_data.count;
                    w_ctl.free_en = w_finish;
                end
            end
            FN_WAIT: begin
                if (!r_oor) begin
                    if (c != CNT_MIN) begin
                        c = c - 16'sd1;
                    end
                    n_count         = c;
                    n_block         = c[COUNT_W-1];
                    w_wr_en         = w_finish;
                    w_wr_data.count = c;
                end
            end
            FN_SIGNAL: begin
                if (!r_oor) begin
                    if (c != CNT_MAX) begin
                        c = c + 16'sd1;
                    end
                    n_count         = c;
                    n_wake          = c[COUNT_W-1] || (c == '0);
                    w_wr_en         = w_finish;
                    w_wr_data.count = c;
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_func  <= t_func'(i_req.func);
                        r_slot  <= i_req.slot_index;
                        r_init  <= i_req.initial_count;
                        r_owner <= i_req.owner_thread;
                        r_oor   <= w_oor_in;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_finish) begin
                        r_status <= n_status;
                        r_gslot  <= n_gslot;
                        r_block  <= n_block;
                        r_wake   <= n_wake;
                        r_count  <= n_count;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.granted_slot = r_gslot;
    assign o_rsp.must_block   = r_block;
    assign o_rsp.wake_one     = r_wake;
    assign o_rsp.count_after  = r_count;

    `STE_ASSERT_NEXT(a_one_request_in_flight, i_clk, i_rst_n, w_accept, !i_req.ready, "request accepted while another is in flight")
    `STE_ASSERT_NEXT(a_finish_sets_valid, i_clk, i_rst_n, w_finish, o_rsp.valid, "finished request did not present a result")
    `STE_ASSERT_SAME(a_no_slot_zeroes, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status == STS_NO_SLOT), (o_rsp.granted_slot == '0) && (o_rsp.count_after == '0), "failed create reports a slot or count")
    `STE_ASSERT_SAME(a_flags_exclusive, i_clk, i_rst_n, o_rsp.valid, !(o_rsp.must_block && o_rsp.wake_one), "block and wake flagged together")

endmodule

// File: hdl/ste_mem.sv
// ----------------------------------------------------------------------------
// Semaphore entry memory
// One-write, one-read synchronous memory holding owner and count per slot,
// with a registered read port.
// ----------------------------------------------------------------------------
module ste_mem #(
    parameter int NUM_SLOTS = ste_pkg::STE_NUM_SLOTS,
    parameter int SW        = $clog2(NUM_SLOTS)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [SW-1:0]    i_rd_addr,
    output ste_pkg::t_entry  o_rd_data,
    input  logic             i_wr_en,
    input  logic [SW-1:0]    i_wr_addr,
    input  ste_pkg::t_entry  i_wr_data
);
    import ste_pkg::*;

    t_entry r_mem [NUM_SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/ste_search.sv
// ----------------------------------------------------------------------------
// Semaphore free-slot search
// Holds the in-use flags and the rotating search pointer. A registered first
// stage encodes each group of flags; the second stage picks the first group
// at or after the pointer, wrapping to the lowest free slot.
// ----------------------------------------------------------------------------
module ste_search #(
    parameter int NUM_SLOTS = ste_pkg::STE_NUM_SLOTS,
    parameter int SW        = $clog2(NUM_SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ste_pkg::t_flag_ctl i_ctl,
    input  logic [SW-1:0]      i_free_slot,
    output logic               o_found,
    output logic [SW-1:0]      o_cand
);
    import ste_pkg::*;

    localparam int NG = (NUM_SLOTS + STE_GROUP - 1) / STE_GROUP;
    localparam int PW = NG * STE_GROUP;

    logic [NUM_SLOTS-1:0]  r_flags;
    logic [SW-1:0]         r_start;
    logic [NG-1:0]         r_hi_any;
    logic [NG-1:0]         r_lo_any;
    logic [NG-1:0]         n_hi_any;
    logic [NG-1:0]         n_lo_any;
    logic [STE_GPOS_W-1:0] r_hi_pos [NG];
    logic [STE_GPOS_W-1:0] r_lo_pos [NG];
    logic [STE_GPOS_W-1:0] n_hi_pos [NG];
    logic [STE_GPOS_W-1:0] n_lo_pos [NG];
    logic [PW-1:0]         w_free;
    logic [SW-1:0]         w_next;

    // Padding beyond the last slot reads as in use.
    assign w_free = PW'(~r_flags);

    // Per group: lowest free slot overall, and lowest free slot at or after
    // the pointer. Scanning downwards lets the lowest position win.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_hi_any[g] = 1'b0;
            n_lo_any[g] = 1'b0;
            n_hi_pos[g] = '0;
            n_lo_pos[g] = '0;
            for (int j = STE_GROUP - 1; j >= 0; j--) begin
                if (w_free[g * STE_GROUP + j]) begin
                    n_lo_any[g] = 1'b1;
                    n_lo_pos[g] = STE_GPOS_W'(j);
                    if ((g * STE_GROUP + j) >= int'(r_start)) begin
                        n_hi_any[g] = 1'b1;
                        n_hi_pos[g] = STE_GPOS_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_hi_any <= n_hi_any;
            r_lo_any <= n_lo_any;
            r_hi_pos <= n_hi_pos;
            r_lo_pos <= n_lo_pos;
        end
    end

    always_comb begin
        logic          lo_found;
        logic          hi_found;
        logic [SW-1:0] lo_slot;
        logic [SW-1:0] hi_slot;
        lo_found = 1'b0;
        hi_found = 1'b0;
        lo_slot  = '0;
        hi_slot  = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_lo_any[g]) begin
                lo_found = 1'b1;
                lo_slot  = SW'(g * STE_GROUP) + SW'(r_lo_pos[g]);
            end
            if (r_hi_any[g]) begin
                hi_found = 1'b1;
                hi_slot  = SW'(g * STE_GROUP) + SW'(r_hi_pos[g]);
            end
        end
        o_found = lo_found;
        o_cand  = hi_found ? hi_slot : lo_slot;
    end

    assign w_next = (o_cand == SW'(NUM_SLOTS - 1)) ? '0 : o_cand + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_start <= '0;
        end else begin
            if (i_ctl.claim) begin
                r_flags[o_cand] <= 1'b1;
                r_start         <= w_next;
            end
            if (i_ctl.free_en) begin
                r_flags[i_free_slot] <= 1'b0;
            end
        end
    end

endmodule

// File: test/tb_semaphore_table_engine.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Semaphore table engine testbench
// Drives create, destroy, wait and signal requests into the engine and checks
// every response against a behavioural copy of the semaphore table. The run
// has a short directed opening, then rounds that fill the table to the full
// case and drain it again, and it ends with a run of waits that takes one
// count well below zero. Both channels idle and stall at random until that
// final stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                               status;
    logic [ste_pkg::SLOT_W-1:0]         slot;
    logic                               blk;
    logic                               wake;
    logic signed [ste_pkg::COUNT_W-1:0] cnt;
} t_sem_result;

class SemTableScoreboard;
    logic signed [ste_pkg::COUNT_W-1:0] count_tbl [ste_pkg::STE_NUM_SLOTS];
    bit                                 live      [ste_pkg::STE_NUM_SLOTS];
    bit                                 written   [ste_pkg::STE_NUM_SLOTS];
    int                                 written_count;
    logic [ste_pkg::SLOT_W-1:0]         probe_ptr;
    logic [ste_pkg::SLOT_W-1:0]         last_slot;
    t_sem_result                        expected_q [$];
    int                                 errors;

    function new();
        probe_ptr     = '0;
        last_slot     = '0;
        errors        = 0;
        written_count = 0;
        foreach (live[i]) begin
            live[i]      = 1'b0;
            written[i]   = 1'b0;
            count_tbl[i] = '0;
        end
    endfunction

    function int live_count();
        int n;
        n = 0;
        foreach (live[i]) n += live[i];
        return n;
    endfunction

    // Works out the response to one accepted request and queues it.
    function void note_request(ste_pkg::t_func fn, logic [ste_pkg::SLOT_W-1:0] slot,
                               logic [ste_pkg::INIT_W-1:0] init);
        t_sem_result                        res;
        logic signed [ste_pkg::COUNT_W-1:0] c;
        logic [ste_pkg::SLOT_W-1:0]         cand;
        bit                                 found;
        int                                 probe;
        res   = '0;
        found = 1'b0;
        case (fn)
            ste_pkg::FN_CREATE: begin
                // The table is a power of two in size, so the pointer wraps
                // by itself. A full table leaves it where it started.
                for (probe = 0; probe < ste_pkg::STE_NUM_SLOTS && !found; probe++) begin
                    cand      = probe_ptr;
                    probe_ptr = probe_ptr + 1'b1;
                    if (!live[cand]) begin
                        found           = 1'b1;
                        live[cand]      = 1'b1;
                        if (!written[cand]) written_count++;
                        written[cand]   = 1'b1;
                        count_tbl[cand] = {1'b0, init};
                        res.slot        = cand;
                        res.cnt         = {1'b0, init};
                    end
                end
                if (!found) res.status = ste_pkg::STS_NO_SLOT;
            end
            ste_pkg::FN_DESTROY: begin
                live[slot] = 1'b0;
                res.slot   = slot;
                res.cnt    = count_tbl[slot];
            end
            ste_pkg::FN_WAIT: begin
                c = count_tbl[slot];
                if (c != ste_pkg::CNT_MIN) c = c - 16'sd1;
                count_tbl[slot] = c;
                res.slot        = slot;
                res.blk         = (c < 0);
                res.cnt         = c;
            end
            default: begin
                c = count_tbl[slot];
                if (c != ste_pkg::CNT_MAX) c = c + 16'sd1;
                count_tbl[slot] = c;
                res.slot        = slot;
                res.wake        = (c <= 0);
                res.cnt         = c;
            end
        endcase
        last_slot = res.slot;
        expected_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(t_sem_result got);
        t_sem_result exp;
        if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected, expected none, actual %0h",
                     $time, got);
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        compare_field("status",       16'(exp.status), 16'(got.status));
        compare_field("granted_slot", 16'(exp.slot),   16'(got.slot));
        compare_field("must_block",   16'(exp.blk),    16'(got.blk));
        compare_field("wake_one",     16'(exp.wake),   16'(got.wake));
        compare_field("count_after",  exp.cnt,         got.cnt);
    endfunction
endclass

module tb_semaphore_table_engine;
    import ste_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 460;
    localparam int FINAL_WAITS  = 24;

    logic i_clk;
    logic i_rst_n;

    ste_req_if req_if ();
    ste_rsp_if rsp_if ();

    SemTableScoreboard sem_sb;
    bit                idle_on   = 1'b1;
    int                rsp_hold  = 0;
    int                cycle_cnt = 0;

    semaphore_table_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("semaphore_table_engine regression: fail");
            $finish;
        end
    end

    // Response side: checks each accepted response and stalls in bursts.
    always @(posedge i_clk) begin : rsp_side
        t_sem_result got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status = rsp_if.status;
            got.slot   = rsp_if.granted_slot;
            got.blk    = rsp_if.must_block;
            got.wake   = rsp_if.wake_one;
            got.cnt    = rsp_if.count_after;
            sem_sb.check_result(got);
        end
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= (rsp_hold == 0);
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_hold = $urandom_range(1, 16);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic issue_request(t_func fn, logic [SLOT_W-1:0] slot,
                                 logic [INIT_W-1:0] init, logic [OWNER_W-1:0] owner);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.func          <= fn;
        req_if.slot_index    <= slot;
        req_if.initial_count <= init;
        req_if.owner_thread  <= owner;
        do @(posedge i_clk); while (!req_if.ready);
        sem_sb.note_request(fn, slot, init);
    endtask

    // Picks a slot whose count has been written, preferring live ones on request.
    function automatic logic [SLOT_W-1:0] pick_slot(bit live_only);
        int cand [$];
        foreach (sem_sb.written[i])
            if (sem_sb.written[i] && (!live_only || sem_sb.live[i])) cand.push_back(i);
        if (cand.size() == 0)
            foreach (sem_sb.written[i]) if (sem_sb.written[i]) cand.push_back(i);
        return SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    task automatic random_request(int create_pct, int destroy_pct);
        int                roll;
        t_func             fn;
        logic [SLOT_W-1:0] slot;
        logic [INIT_W-1:0] init;
        roll = $urandom_range(0, 99);
        if (sem_sb.written_count == 0 || roll < create_pct)
            fn = FN_CREATE;
        else if (roll < create_pct + destroy_pct)
            fn = FN_DESTROY;
        else if (roll % 2)
            fn = FN_WAIT;
        else
            fn = FN_SIGNAL;
        if (fn == FN_CREATE)
            slot = SLOT_W'($urandom);
        else
            slot = pick_slot($urandom_range(0, 3) != 0);
        // Small counts keep waits and signals crossing zero.
        if ($urandom_range(0, 3) == 0)
            init = INIT_W'($urandom);
        else
            init = INIT_W'($urandom_range(0, 4));
        issue_request(fn, slot, init, OWNER_W'($urandom));
    endtask

    initial begin
        int                sent;
        int                n;
        int                full_hits;
        logic [SLOT_W-1:0] sat_slot;

        sem_sb = new();
        req_if.valid         <= 1'b0;
        req_if.func          <= FN_CREATE;
        req_if.slot_index    <= '0;
        req_if.initial_count <= '0;
        req_if.owner_thread  <= '0;
        i_rst_n              <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: field extremes, every operation, positive
        // saturation, operations on a freed slot and wake-up at zero.
        issue_request(FN_CREATE,  6'h3f, 15'h0000, 8'h00);
        issue_request(FN_CREATE,  6'h00, 15'h7fff, 8'hff);
        issue_request(FN_SIGNAL,  6'd1,  15'h7fff, 8'hff);
        issue_request(FN_WAIT,    6'd0,  15'h0000, 8'h00);
        issue_request(FN_SIGNAL,  6'd0,  15'h0000, 8'h00);
        issue_request(FN_SIGNAL,  6'd0,  15'h0000, 8'h00);
        issue_request(FN_WAIT,    6'd0,  15'h0000, 8'h00);
        issue_request(FN_DESTROY, 6'd1,  15'h0000, 8'h00);
        issue_request(FN_WAIT,    6'd1,  15'h0000, 8'h00);
        issue_request(FN_DESTROY, 6'd1,  15'h0000, 8'h00);
        issue_request(FN_CREATE,  6'h2a, 15'h5555, 8'haa);
        issue_request(FN_CREATE,  6'h15, 15'h2aaa, 8'h55);
        issue_request(FN_SIGNAL,  6'd1,  15'h0000, 8'h00);
        issue_request(FN_DESTROY, 6'd0,  15'h0000, 8'h00);
        issue_request(FN_WAIT,    6'd3,  15'h0000, 8'h00);
        issue_request(FN_SIGNAL,  6'd2,  15'h0000, 8'h00);

        // Rounds that fill the table, try a few creates on a full table,
        // then destroy their way back down to empty.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            n         = 0;
            full_hits = 0;
            while (full_hits < 4 && n < 300 && sent + n < RANDOM_ITEMS) begin
                if (sem_sb.live_count() == STE_NUM_SLOTS) begin
                    full_hits++;
                    random_request(100, 0);
                end else begin
                    random_request(70, 10);
                end
                n++;
            end
            while (sem_sb.live_count() > 0 && n < 600 && sent + n < RANDOM_ITEMS) begin
                random_request(10, 60);
                n++;
            end
            sent += n;
        end

        // Last stretch without idling: walk one count well below zero and
        // step it back up once.
        idle_on = 1'b0;
        if (sem_sb.live_count() == STE_NUM_SLOTS)
            issue_request(FN_DESTROY, pick_slot(1'b1), INIT_W'($urandom),
                          OWNER_W'($urandom));
        issue_request(FN_CREATE, SLOT_W'($urandom), '0, OWNER_W'($urandom));
        sat_slot = sem_sb.last_slot;
        repeat (FINAL_WAITS)
            issue_request(FN_WAIT, sat_slot, INIT_W'($urandom), OWNER_W'($urandom));
        issue_request(FN_SIGNAL, sat_slot, INIT_W'($urandom), OWNER_W'($urandom));
        req_if.valid <= 1'b0;

        while (sem_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sem_sb.errors == 0) begin
            $display("semaphore_table_engine regression: pass");
        end else begin
            $display("semaphore_table_engine regression: fail");
        end
        $finish;
    end

endmodule
